### sv/spq_pkg.sv
package spq_pkg;

	localparam int VALUE_W = 11;
	localparam int OCC_W   = 5;
	localparam int STAT_W  = 2;

	typedef logic signed [VALUE_W-1:0] value_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] REG_DESCENDING     = 2'd0;
	localparam logic [1:0] REG_TAKE_FROM_TAIL = 2'd1;
	localparam logic [1:0] REG_TIES_BEHIND    = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP_HEAD,
		OP_POP_TAIL
	} op_t;

	typedef struct packed {
		op_t    op;
		logic   descending;
		logic   ties_behind;
		value_t value;
	} cell_ctrl_t;

	typedef struct packed {
		logic   take;
		logic   occ;
		logic   is_tail;
		value_t value;
	} cell_stat_t;

endpackage

### sv/spq_cell.sv
module spq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                left_take,
	input  logic                left_occ,
	input  spq_pkg::value_t     left_value,
	input  logic                right_occ,
	input  spq_pkg::value_t     right_value,
	output spq_pkg::cell_stat_t stat
);
	import spq_pkg::*;

	value_t value_q;
	logic   occ_q;
	value_t value_d;
	logic   occ_d;
	logic   goes_ahead;

	always_comb begin
		if (ctrl.descending) begin
			goes_ahead = ctrl.ties_behind ? (value_q < ctrl.value) : (value_q <= ctrl.value);
		end else begin
			goes_ahead = ctrl.ties_behind ? (value_q > ctrl.value) : (value_q >= ctrl.value);
		end
	end

	always_comb begin
		stat.take    = !occ_q || goes_ahead;
		stat.occ     = occ_q;
		stat.is_tail = occ_q && !right_occ;
		stat.value   = value_q;
	end

	always_comb begin
		value_d = value_q;
		occ_d   = occ_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (left_take) begin
					value_d = left_value;
					occ_d   = left_occ;
				end else if (stat.take) begin
					value_d = ctrl.value;
					occ_d   = 1'b1;
				end
			end
			OP_POP_HEAD: begin
				value_d = right_value;
				occ_d   = right_occ;
			end
			OP_POP_TAIL: begin
				occ_d = occ_q && right_occ;
			end
			default: begin
				value_d = value_q;
				occ_d   = occ_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

endmodule

### sv/sorted_priority_queue.sv
// Sorted priority queue built as a row of CAPACITY cells, one held value per cell,
// head in the first cell. Every cell compares the incoming value with its own entry
// at once, so an insert, a head remove or a tail remove is done by all cells together,
// and a new command is taken every cycle while s_axis_tready is high; the result of a
// command appears in the output register on the next cycle, and s_axis_tready drops
// only while that register holds a result that has not been taken. Order (ascending
// or descending), the end a remove takes from, and the placement among equal values
// are set through the APB registers and must be written while no command is in flight.
// No clearing pass follows reset: the queue is empty and ready at once.
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [10:0] value
	input  logic        s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [10:0] removed_value, [12:11] status, [17:13] occupancy
	output logic        m_axis_tuser,  // [0] removed_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic             descending_q;
	logic             take_from_tail_q;
	logic             ties_behind_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             m_valid_q;
	value_t           m_value_q;
	logic             m_rvalid_q;
	logic [STAT_W-1:0] m_status_q;
	logic [OCC_W-1:0] m_occ_q;

	logic             s_fire;
	logic             wr_en;
	logic             full;
	logic             empty;
	value_t           in_value;
	cell_ctrl_t       ctrl;
	cell_stat_t       stat [CAPACITY];
	logic [CAPACITY:0] take_w;
	logic [CAPACITY:0] occ_w;
	value_t           val_w [CAPACITY+1];
	logic [CAPACITY-1:0] tail_vec;
	value_t           tail_value;
	value_t           removed_d;
	logic             rvalid_d;
	logic [STAT_W-1:0] status_d;

	assign pready        = 1'b1;
	assign wr_en         = psel && penable && pwrite && pready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign in_value      = s_axis_tdata[VALUE_W-1:0];
	assign full          = (count_q == CNT_W'(CAPACITY));
	assign empty         = (count_q == '0);

	always_comb begin
		case (paddr[3:2])
			REG_DESCENDING:     prdata = {31'd0, descending_q};
			REG_TAKE_FROM_TAIL: prdata = {31'd0, take_from_tail_q};
			REG_TIES_BEHIND:    prdata = {31'd0, ties_behind_q};
			default:            prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q     <= 1'b0;
			take_from_tail_q <= 1'b0;
			ties_behind_q    <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DESCENDING:     descending_q     <= pwdata[0];
				REG_TAKE_FROM_TAIL: take_from_tail_q <= pwdata[0];
				REG_TIES_BEHIND:    ties_behind_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ctrl.op          = OP_HOLD;
		ctrl.descending  = descending_q;
		ctrl.ties_behind = ties_behind_q;
		ctrl.value       = in_value;
		count_d          = count_q;
		status_d         = ST_OK;
		rvalid_d         = 1'b0;
		removed_d        = '0;
		if (s_axis_tuser == CMD_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				ctrl.op = s_fire ? OP_INSERT : OP_HOLD;
				count_d = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				ctrl.op   = s_fire ? (take_from_tail_q ? OP_POP_TAIL : OP_POP_HEAD) : OP_HOLD;
				count_d   = count_q - 1'b1;
				rvalid_d  = 1'b1;
				removed_d = take_from_tail_q ? tail_value : val_w[0];
			end
		end
	end

	assign take_w[0] = 1'b0;
	assign occ_w[CAPACITY] = 1'b0;
	assign val_w[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_take   (take_w[i]),
			.left_occ    ((i == 0) ? 1'b0 : occ_w[(i == 0) ? 0 : i - 1]),
			.left_value  (val_w[(i == 0) ? CAPACITY : i - 1]),
			.right_occ   (occ_w[i+1]),
			.right_value (val_w[i+1]),
			.stat        (stat[i])
		);
		assign take_w[i+1] = stat[i].take;
		assign occ_w[i]    = stat[i].occ;
		assign val_w[i]    = stat[i].value;
		assign tail_vec[i] = stat[i].is_tail;
	end

	always_comb begin
		tail_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_value = tail_value | (val_w[i] & {VALUE_W{tail_vec[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				count_q <= count_d;
			end
			if (s_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_value_q  <= removed_d;
			m_rvalid_q <= rvalid_d;
			m_status_q <= status_d;
			m_occ_q    <= OCC_W'(count_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_occ_q, m_status_q, m_value_q};
	assign m_axis_tuser  = m_rvalid_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_tail_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tail_vec))
		else $error("more than one tail cell");

	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_w[0] == (count_q != '0))
		else $error("head cell occupancy disagrees with count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser == CMD_INSERT && full) |=>
		(m_status_q == ST_FULL && $stable(count_q)))
		else $error("insert on full queue not dropped");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_COMMANDS = 75;

	typedef struct packed {
		logic   cmd;
		value_t value;
	} queue_cmd_t;

	typedef struct packed {
		value_t              removed;
		logic                removed_valid;
		logic [STAT_W-1:0]   status;
		logic [OCC_W-1:0]    occupancy;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = CMD_INSERT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sorted_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),   // [10:0] value
		.s_axis_tuser(s_axis_tuser),   // [0] cmd
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),   // [10:0] removed_value, [12:11] status, [17:13] occupancy
		.m_axis_tuser(m_axis_tuser),   // [0] removed_valid
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	value_t        held_values[$];
	logic          order_desc = 1'b0;
	logic          take_tail = 1'b0;
	logic          ties_last = 1'b0;
	queue_cmd_t    pending_cmds[$];
	queue_result_t expected_results[$];
	queue_cmd_t    next_cmd;
	queue_result_t seen;
	queue_result_t want;
	logic          sender_calm = 1'b0;
	logic          receiver_calm = 1'b0;
	int            send_gap;
	int            recv_stall;
	int            hold;
	int            cycle_count = 0;
	int            mismatch_count = 0;
	int            insert_count = 0;
	int            remove_count = 0;
	int            empty_count = 0;
	int            full_count = 0;
	int            settings_used = 0;

	function automatic queue_result_t apply_command(input logic cmd, input value_t x);
		queue_result_t r;
		int pos;
		logic placed;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			insert_count++;
			if (held_values.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				full_count++;
			end else begin
				pos = 0;
				placed = 1'b0;
				while (!placed && pos < held_values.size()) begin
					if (order_desc)
						placed = ties_last ? (held_values[pos] < x) : (held_values[pos] <= x);
					else
						placed = ties_last ? (held_values[pos] > x) : (held_values[pos] >= x);
					if (!placed)
						pos++;
				end
				held_values.insert(pos, x);
			end
		end else begin
			remove_count++;
			if (held_values.size() == 0) begin
				r.status = ST_EMPTY;
				empty_count++;
			end else begin
				r.removed = take_tail ? held_values.pop_back() : held_values.pop_front();
				r.removed_valid = 1'b1;
			end
		end
		r.occupancy = OCC_W'(held_values.size());
		return r;
	endfunction

	function automatic value_t pick_value();
		value_t corners[6];
		corners = '{value_t'(-1000), value_t'(1000), value_t'(-1024), value_t'(1023),
			value_t'(0), value_t'(-1)};
		case ($urandom_range(0, 9))
			0: return value_t'($urandom_range(0, 2047));
			1: return corners[$urandom_range(0, 5)];
			2, 3: return value_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return value_t'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= CMD_INSERT;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(
					apply_command(s_axis_tuser, s_axis_tdata[VALUE_W-1:0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, next_cmd.value};
					s_axis_tuser <= next_cmd.cmd;
					send_gap <= sender_calm ? 0 : $urandom_range(0, 9);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.removed = m_axis_tdata[10:0];
				seen.status = m_axis_tdata[12:11];
				seen.occupancy = m_axis_tdata[17:13];
				seen.removed_valid = m_axis_tuser;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("cycle %0d: unexpected result %0d/%0b/%0d/%0d",
							cycle_count, seen.removed, seen.removed_valid, seen.status,
							seen.occupancy);
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("cycle %0d: want %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
								cycle_count, want.removed, want.removed_valid, want.status,
								want.occupancy, seen.removed, seen.removed_valid, seen.status,
								seen.occupancy);
					end
				end
				hold = receiver_calm ? 0 : $urandom_range(0, 9);
				recv_stall <= hold;
				m_axis_tready <= (hold == 0);
			end else if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= (recv_stall == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] index, input logic bit_value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= {31'b0, bit_value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_DESCENDING: order_desc = bit_value;
			REG_TAKE_FROM_TAIL: take_tail = bit_value;
			REG_TIES_BEHIND: ties_last = bit_value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	// empty the queue before the order can change
	task automatic drain_queue();
		wait_idle();
		repeat (held_values.size() + 1)
			pending_cmds.push_back('{cmd: CMD_REMOVE, value: pick_value()});
		wait_idle();
	endtask

	task automatic queue_random_phase(input int count);
		int left;
		int run;
		logic bias;
		left = count;
		bias = CMD_INSERT;
		while (left > 0) begin
			run = $urandom_range(1, 20);
			if (run > left)
				run = left;
			repeat (run)
				pending_cmds.push_back('{cmd: ($urandom_range(0, 99) < 85) ? bias : ~bias,
					value: pick_value()});
			left -= run;
			bias = ~bias;
		end
	endtask

	initial begin
		int phase;
		int leftover;
		logic [2:0] setting;
		value_t directed_values[8];
		directed_values = '{value_t'(0), value_t'(1023), value_t'(-1024), value_t'(1000),
			value_t'(-1000), value_t'(0), value_t'(-1), value_t'(1)};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_cmds.push_back('{cmd: CMD_REMOVE, value: value_t'(0)});
		foreach (directed_values[i])
			pending_cmds.push_back('{cmd: CMD_INSERT, value: directed_values[i]});
		repeat (9)
			pending_cmds.push_back('{cmd: CMD_REMOVE, value: value_t'(-1)});
		drain_queue();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			setting = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			write_reg(REG_DESCENDING, setting[0]);
			write_reg(REG_TAKE_FROM_TAIL, setting[1]);
			write_reg(REG_TIES_BEHIND, setting[2]);
			settings_used++;
			sender_calm = (phase == 3 || phase == 6);
			receiver_calm = (phase == 3 || phase == 7);
			queue_random_phase(PHASE_COMMANDS);
			drain_queue();
		end

		wait_idle();
		repeat (4) @(posedge clk);
		leftover = expected_results.size();
		if (leftover != 0)
			$display("%0d expected results never arrived", leftover);
		$display("Sent %0d commands: %0d inserts (%0d on full), %0d removes (%0d on empty).",
			insert_count + remove_count, insert_count, full_count, remove_count, empty_count);
		$display("Visited %0d register settings, all order, end and tie choices among them.",
			settings_used);
		if (mismatch_count == 0 && leftover == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
